// ===== rtl/mpd_pkg.sv =====
// Shared types, constants and codes for the mouse packet decoder.
`default_nettype none

package mpd_pkg;

  // Default pointer coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int DELTA_W    = 9;   // sum of two signed delta bytes
  localparam int MAG_W      = 9;   // |delta| reaches 256
  localparam int PROD_W     = 16;  // (mag - thr) * num never exceeds 65280 when mag > thr
  localparam int RATIO_W    = 8;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int BTN_W      = 3;

  // Register reset values
  localparam logic [RATIO_W-1:0] THRESH_RST = 8'd4;
  localparam logic [RATIO_W-1:0] NUM_RST    = 8'd2;
  localparam logic [RATIO_W-1:0] DEN_RST    = 8'd1;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1152;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd900;

  // Cursor starts at the middle of the default screen
  localparam int CURSOR_X_RST = 576;
  localparam int CURSOR_Y_RST = 450;

  // Sync byte recognition: 0x80..0x8F
  localparam logic [BYTE_W-1:0] SYNC_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] SYNC_CODE = 8'h80;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_NUMERATOR   = 3'd1,
    REG_DENOMINATOR = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_HEIGHT      = 3'd4
  } cfg_reg_t;

  // Result kinds
  typedef enum logic [1:0] {
    EVT_MOTION  = 2'd0,
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2
  } evt_kind_t;

  // Position inside a five-byte packet
  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_DX1  = 3'd1,
    PH_DY1  = 3'd2,
    PH_DX2  = 3'd3,
    PH_DY2  = 3'd4
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MUL    = 3'd1,
    ST_DSTART = 3'd2,
    ST_DWAIT  = 3'd3,
    ST_APPLY  = 3'd4,
    ST_EMIT   = 3'd5
  } ctl_state_t;

  // Event slots: motion first, then buttons of bit 0, 1, 2
  localparam logic [1:0] SLOT_MOTION = 2'd0;
  localparam int         NUM_SLOTS   = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic       byte_take;
    logic       axis_y;
    logic       mul_ld;
    logic       div_start;
    logic       apply;
    logic       evt_ld;
    logic [1:0] evt_slot;
    logic       evt_last;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic                 pkt_end;
    logic [NUM_SLOTS-1:0] evt_mask;
    logic                 div_busy;
    logic                 div_done;
    logic                 out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mpd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module mpd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mpd_pkg::PROD_W-1:0]    dividend,
  input  wire logic [mpd_pkg::RATIO_W-1:0]   divisor,
  output logic      [mpd_pkg::PROD_W-1:0]    quotient,
  output logic                               busy,
  output logic                               done
);

  localparam int CNT_W = $clog2(mpd_pkg::PROD_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [mpd_pkg::PROD_W-1:0]    quo_r, quo_nxt;
  logic [mpd_pkg::RATIO_W-1:0]   rem_r, rem_nxt;
  logic [mpd_pkg::RATIO_W-1:0]   dsr_r, dsr_nxt;
  logic [mpd_pkg::RATIO_W:0]     trial;
  logic                          fits;

  // Load on start, otherwise one shift-and-subtract step while busy
  always_comb begin
    trial    = {rem_r, quo_r[mpd_pkg::PROD_W-1]};
    fits     = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(mpd_pkg::PROD_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? mpd_pkg::RATIO_W'(trial - {1'b0, dsr_r})
                     : trial[mpd_pkg::RATIO_W-1:0];
      quo_nxt = {quo_r[mpd_pkg::PROD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== rtl/mpd_dpath.sv =====
// Datapath: packet assembly, acceleration, clamping and the result register.
`default_nettype none

module mpd_dpath #(
  parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input byte
  input  wire logic [mpd_pkg::BYTE_W-1:0]         data_byte,
  // controller link
  input  wire mpd_pkg::ctl_cmd_t                  cmd,
  output mpd_pkg::dp_stat_t                       stat,
  // result register
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [1:0]                              event_kind,
  output logic [1:0]                              button_number,
  output logic [COORD_BITS-1:0]                   pos_x,
  output logic [COORD_BITS-1:0]                   pos_y,
  output logic                                    last
);

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int CUR_X_RST = (mpd_pkg::CURSOR_X_RST > COORD_MAX) ? COORD_MAX
                                                                 : mpd_pkg::CURSOR_X_RST;
  localparam int CUR_Y_RST = (mpd_pkg::CURSOR_Y_RST > COORD_MAX) ? COORD_MAX
                                                                 : mpd_pkg::CURSOR_Y_RST;
  localparam int LW = (COORD_BITS > mpd_pkg::SIZE_W) ? COORD_BITS : mpd_pkg::SIZE_W;
  localparam int SW = ((COORD_BITS > mpd_pkg::PROD_W) ? COORD_BITS : mpd_pkg::PROD_W) + 2;

  // Configuration registers
  logic [mpd_pkg::RATIO_W-1:0] thr_r, num_r, den_r;
  logic [mpd_pkg::SIZE_W-1:0]  width_r, height_r;

  // Packet state
  mpd_pkg::phase_t                    phase_r, phase_nxt;
  logic [mpd_pkg::BTN_W-1:0]          btn_r, btn_nxt;
  logic [mpd_pkg::BTN_W-1:0]          chg_r, chg_nxt;
  logic signed [mpd_pkg::DELTA_W-1:0] sum_dx_r, sum_dx_nxt;
  logic signed [mpd_pkg::DELTA_W-1:0] sum_dy_r, sum_dy_nxt;
  logic [COORD_BITS-1:0]              cur_x_r, cur_y_r;

  // Acceleration stage
  logic [mpd_pkg::PROD_W-1:0] prod_r;
  logic [mpd_pkg::MAG_W-1:0]  mag_r;
  logic                       neg_r, over_r;

  // Result register
  logic                  ovld_r;
  logic [1:0]            okind_r, obtn_r;
  logic [COORD_BITS-1:0] ox_r, oy_r;
  logic                  olast_r;

  logic signed [mpd_pkg::DELTA_W-1:0] delta_s;
  logic signed [mpd_pkg::DELTA_W-1:0] axis_sum;
  logic [mpd_pkg::MAG_W-1:0]          mag;
  logic [mpd_pkg::MAG_W-1:0]          excess;
  logic [mpd_pkg::MAG_W+mpd_pkg::RATIO_W-1:0] prod_full;
  logic                               moved;

  logic [mpd_pkg::RATIO_W-1:0] den_eff;
  logic [mpd_pkg::PROD_W-1:0]  quo;
  logic                        div_busy, div_done;

  logic [mpd_pkg::PROD_W-1:0]  acc_mag;
  logic [COORD_BITS-1:0]       cur_sel;
  logic [mpd_pkg::SIZE_W-1:0]  size_sel, lim13;
  logic [LW-1:0]               lim_w, lim_c;
  logic signed [SW-1:0]        cur_s, acc_s, lim_s, new_s;
  logic [COORD_BITS-1:0]       clamped;
  logic [1:0]                  btn_idx;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= mpd_pkg::THRESH_RST;
      num_r    <= mpd_pkg::NUM_RST;
      den_r    <= mpd_pkg::DEN_RST;
      width_r  <= mpd_pkg::WIDTH_RST;
      height_r <= mpd_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpd_pkg::REG_THRESHOLD:   thr_r    <= cfg_data[mpd_pkg::RATIO_W-1:0];
        mpd_pkg::REG_NUMERATOR:   num_r    <= cfg_data[mpd_pkg::RATIO_W-1:0];
        mpd_pkg::REG_DENOMINATOR: den_r    <= cfg_data[mpd_pkg::RATIO_W-1:0];
        mpd_pkg::REG_WIDTH:       width_r  <= cfg_data;
        mpd_pkg::REG_HEIGHT:      height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte sequencing through the packet
  always_comb begin
    delta_s    = $signed({data_byte[mpd_pkg::BYTE_W-1], data_byte});
    phase_nxt  = phase_r;
    btn_nxt    = btn_r;
    chg_nxt    = chg_r;
    sum_dx_nxt = sum_dx_r;
    sum_dy_nxt = sum_dy_r;
    if (cmd.byte_take) begin
      unique case (phase_r)
        mpd_pkg::PH_SYNC: begin
          if ((data_byte & mpd_pkg::SYNC_MASK) == mpd_pkg::SYNC_CODE) begin
            btn_nxt   = ~data_byte[mpd_pkg::BTN_W-1:0];
            chg_nxt   = btn_r ^ ~data_byte[mpd_pkg::BTN_W-1:0];
            phase_nxt = mpd_pkg::PH_DX1;
          end
        end
        mpd_pkg::PH_DX1: begin
          sum_dx_nxt = delta_s;
          phase_nxt  = mpd_pkg::PH_DY1;
        end
        mpd_pkg::PH_DY1: begin
          sum_dy_nxt = delta_s;
          phase_nxt  = mpd_pkg::PH_DX2;
        end
        mpd_pkg::PH_DX2: begin
          sum_dx_nxt = sum_dx_r + delta_s;
          phase_nxt  = mpd_pkg::PH_DY2;
        end
        mpd_pkg::PH_DY2: begin
          sum_dy_nxt = sum_dy_r + delta_s;
          phase_nxt  = mpd_pkg::PH_SYNC;
        end
        default: phase_nxt = mpd_pkg::PH_SYNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mpd_pkg::PH_SYNC;
      btn_r    <= '0;
      chg_r    <= '0;
      sum_dx_r <= '0;
      sum_dy_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      btn_r    <= btn_nxt;
      chg_r    <= chg_nxt;
      sum_dx_r <= sum_dx_nxt;
      sum_dy_r <= sum_dy_nxt;
    end
  end

  // Magnitude, threshold excess and scaling by the numerator
  always_comb begin
    axis_sum  = cmd.axis_y ? sum_dy_r : sum_dx_r;
    mag       = axis_sum[mpd_pkg::DELTA_W-1] ? (~axis_sum + 1'b1) : axis_sum;
    excess    = mag - {1'b0, thr_r};
    prod_full = excess * num_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_r <= prod_full[mpd_pkg::PROD_W-1:0];
      mag_r  <= mag;
      neg_r  <= axis_sum[mpd_pkg::DELTA_W-1];
      over_r <= (mag > {1'b0, thr_r});
    end
  end

  // Division by the denominator (zero counts as one)
  assign den_eff = (den_r == '0) ? mpd_pkg::RATIO_W'(1) : den_r;

  mpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_eff),
    .quotient (quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  // Apply the accelerated delta and clamp to the screen
  always_comb begin
    acc_mag  = over_r ? (mpd_pkg::PROD_W'(thr_r) + quo)
                      : mpd_pkg::PROD_W'(mag_r);
    cur_sel  = cmd.axis_y ? cur_y_r : cur_x_r;
    size_sel = cmd.axis_y ? height_r : width_r;
    lim13    = (size_sel == '0) ? '0 : (size_sel - 1'b1);
    lim_w    = LW'(lim13);
    lim_c    = (lim_w > LW'(COORD_MAX)) ? LW'(COORD_MAX) : lim_w;
    cur_s    = $signed(SW'(cur_sel));
    acc_s    = $signed(SW'(acc_mag));
    lim_s    = $signed(SW'(lim_c));
    // x moves with the delta, y against it
    new_s    = (neg_r ^ cmd.axis_y) ? (cur_s - acc_s) : (cur_s + acc_s);
    if (new_s < 0) begin
      clamped = '0;
    end else if (new_s > lim_s) begin
      clamped = COORD_BITS'(lim_c);
    end else begin
      clamped = new_s[COORD_BITS-1:0];
    end
  end

  assign moved = (sum_dx_r != '0) || (sum_dy_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= COORD_BITS'(CUR_X_RST);
      cur_y_r <= COORD_BITS'(CUR_Y_RST);
    end else if (cmd.apply && moved) begin
      if (cmd.axis_y) begin
        cur_y_r <= clamped;
      end else begin
        cur_x_r <= clamped;
      end
    end
  end

  // Result register: loads a beat when free, drains on out_ready
  assign btn_idx = cmd.evt_slot - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.evt_ld) begin
      ovld_r <= 1'b1;
    end else if (out_ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evt_ld) begin
      if (cmd.evt_slot == mpd_pkg::SLOT_MOTION) begin
        okind_r <= mpd_pkg::EVT_MOTION;
        obtn_r  <= '0;
      end else begin
        okind_r <= btn_r[btn_idx] ? mpd_pkg::EVT_PRESS : mpd_pkg::EVT_RELEASE;
        obtn_r  <= 2'(3'd4 - {1'b0, cmd.evt_slot});
      end
      ox_r    <= cur_x_r;
      oy_r    <= cur_y_r;
      olast_r <= cmd.evt_last;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.pkt_end  = (phase_r == mpd_pkg::PH_DY2);
    stat.evt_mask = {chg_r, moved};
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.out_free = !ovld_r || out_ready;
  end

  assign out_valid     = ovld_r;
  assign event_kind    = okind_r;
  assign button_number = obtn_r;
  assign pos_x         = ox_r;
  assign pos_y         = oy_r;
  assign last          = olast_r;

endmodule

`default_nettype wire

// ===== rtl/mpd_ctrl.sv =====
// Controller: sequences byte intake, per-axis acceleration and event emission.
`default_nettype none

module mpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mpd_pkg::dp_stat_t stat,
  output mpd_pkg::ctl_cmd_t      cmd
);

  mpd_pkg::ctl_state_t            state_r, state_nxt;
  logic                           axis_r, axis_nxt;
  logic [mpd_pkg::NUM_SLOTS-1:0]  pend_r, pend_nxt;
  logic [mpd_pkg::NUM_SLOTS-1:0]  low, rest;
  logic [1:0]                     slot;

  // Lowest pending event slot
  always_comb begin
    low  = pend_r & (~pend_r + 1'b1);
    rest = pend_r & ~low;
    priority if (low[0]) slot = 2'd0;
    else if (low[1])     slot = 2'd1;
    else if (low[2])     slot = 2'd2;
    else                 slot = 2'd3;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      mpd_pkg::ST_IDLE: begin
        if (in_valid && stat.pkt_end) begin
          state_nxt = mpd_pkg::ST_MUL;
          axis_nxt  = 1'b0;
        end
      end
      mpd_pkg::ST_MUL:    state_nxt = mpd_pkg::ST_DSTART;
      mpd_pkg::ST_DSTART: state_nxt = mpd_pkg::ST_DWAIT;
      mpd_pkg::ST_DWAIT: begin
        if (stat.div_done) state_nxt = mpd_pkg::ST_APPLY;
      end
      mpd_pkg::ST_APPLY: begin
        if (!axis_r) begin
          state_nxt = mpd_pkg::ST_MUL;
          axis_nxt  = 1'b1;
        end else if (stat.evt_mask != '0) begin
          state_nxt = mpd_pkg::ST_EMIT;
          pend_nxt  = stat.evt_mask;
        end else begin
          state_nxt = mpd_pkg::ST_IDLE;
        end
      end
      mpd_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          pend_nxt = rest;
          if (rest == '0) state_nxt = mpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpd_pkg::ST_IDLE;
      axis_r  <= 1'b0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_ready      = (state_r == mpd_pkg::ST_IDLE);
    cmd.byte_take = in_ready && in_valid;
    cmd.axis_y    = axis_r;
    cmd.mul_ld    = (state_r == mpd_pkg::ST_MUL);
    cmd.div_start = (state_r == mpd_pkg::ST_DSTART);
    cmd.apply     = (state_r == mpd_pkg::ST_APPLY);
    cmd.evt_ld    = (state_r == mpd_pkg::ST_EMIT) && stat.out_free;
    cmd.evt_slot  = slot;
    cmd.evt_last  = (rest == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/mouse_packet_decoder_accel.sv =====
// Top level of the serial mouse packet decoder with pointer acceleration.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in_     | in        | in_tvalid / in_tready      | in_tdata: data_byte
//  out_    | out       | out_tvalid / out_tready    | out_tdata: kind, button, x, y; out_tlast
//  cfg_    | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  Bytes 1-4 of a packet are taken one per cycle while the controller is idle. The fifth
//  byte runs acceleration for x then y through one 16-step shift-subtract divider (load,
//  start, 16 steps, done, apply for each axis), then event beats (up to four) follow one
//  per cycle while out_tready is high.
//  The result register lets the next byte be taken while the last beat waits.
//  rst_n is synchronous and resets the control, configuration and cursor registers.
`default_nettype none

module mouse_packet_decoder_accel #(
  parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input byte stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] data_byte
  // event stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // low bit up: event_kind[2], button_number[2], pos_x, pos_y, zero fill
  output logic [((4 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                    out_tlast,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OUT_W = ((4 + 2*COORD_BITS + 7) / 8) * 8;

  mpd_pkg::ctl_cmd_t     cmd;
  mpd_pkg::dp_stat_t     stat;
  logic [1:0]            event_kind;
  logic [1:0]            button_number;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  assign cfg_ready = 1'b1;

  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpd_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (in_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .event_kind    (event_kind),
    .button_number (button_number),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .last          (out_tlast)
  );

  // Pack the event beat
  assign out_tdata = OUT_W'({pos_y, pos_x, button_number, event_kind});

`ifndef SYNTHESIS
  // No byte is taken while the divider works
  a_no_take_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !in_tready)
    else $error("byte accepted while divider busy");

  // An event is only loaded into a free result register
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evt_ld |-> stat.out_free)
    else $error("event loaded over a pending beat");

  // Divider is never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // A loaded event shows up as a valid beat next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evt_ld |=> out_tvalid)
    else $error("loaded event not presented");
`endif

endmodule

`default_nettype wire
